@@ hw/rtl/tpf_pkg.sv @@
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared constants, codes and command/status types of the tagged packet FIFO.
// ----------------------------------------------------------------------------
package tpf_pkg;

    localparam int SLOT_DEPTH   = 16;
    localparam int PAYLOAD_DEPTH = 64;

    localparam int SLOT_W       = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int CNT_W        = $clog2(SLOT_DEPTH + 1);
    localparam int PAY_IDX_W    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int ADDR_W       = $clog2(SLOT_DEPTH * PAYLOAD_DEPTH);

    localparam int CAP_W        = 5;
    localparam int LEN_W        = 7;
    localparam int TAG_W        = 16;
    localparam int BYTE_W       = 8;
    localparam int LIMIT_W      = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;
    localparam int CAP_CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_BYTES = 1'b1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [LEN_W-1:0] MAXB_RESET = LEN_W'(64);

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_LARGE = 3'd2,
        ST_EMPTY = 3'd3,
        ST_SMALL = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } t_state;

    typedef struct packed {
        logic    push;
        logic    pop;
        logic    emit;
        t_status emit_code;
        logic    step;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic too_small;
        logic zero_len;
        logic stream_last;
    } t_dp_stat;

    function automatic logic [ADDR_W-1:0] pay_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [PAY_IDX_W-1:0] idx);
        pay_addr = ADDR_W'(slot) * ADDR_W'(PAYLOAD_DEPTH) + ADDR_W'(idx);
    endfunction

endpackage

@@ hw/rtl/tpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpf_ctrl
// Request sequencer: decodes accepted requests into datapath commands and
// walks the pop stream one byte per cycle.
// ----------------------------------------------------------------------------
module tpf_ctrl import tpf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_opcode,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_busy          = 1'b0;
        o_cmd.push      = 1'b0;
        o_cmd.pop       = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.emit_code = ST_OK;
        o_cmd.step      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == OP_PUSH) begin
                        o_cmd.push = 1'b1;
                    end else if (i_stat.empty) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_code = ST_EMPTY;
                    end else if (i_stat.too_small) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_code = ST_SMALL;
                    end else begin
                        o_cmd.pop = 1'b1;
                        if (!i_stat.zero_len) begin
                            n_state = S_STREAM;
                        end
                    end
                end
            end
            S_STREAM: begin
                o_busy     = 1'b1;
                o_cmd.step = 1'b1;
                if (i_stat.stream_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/tpf_datapath.sv @@
// ----------------------------------------------------------------------------
// tpf_datapath
// Config registers, ring pointers, staging state, slot headers, payload
// memory and the result register.
// ----------------------------------------------------------------------------
module tpf_datapath import tpf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    input  logic [TAG_W-1:0]      i_client_in,
    input  logic [TAG_W-1:0]      i_schema_in,
    input  logic [BYTE_W-1:0]     i_push_byte,
    input  logic                  i_push_last,
    input  logic [LIMIT_W-1:0]    i_pop_limit,
    output t_dp_stat              o_stat,
    output logic                  o_strobe,
    output logic [2:0]            o_status,
    output logic [TAG_W-1:0]      o_client_out,
    output logic [TAG_W-1:0]      o_schema_out,
    output logic [BYTE_W-1:0]     o_pop_byte,
    output logic [LEN_W-1:0]      o_message_length,
    output logic                  o_last_result
);

    logic [CAP_W-1:0]   r_cap;
    logic [LEN_W-1:0]   r_maxb;
    logic [SLOT_W-1:0]  r_head;
    logic [SLOT_W-1:0]  r_tail;
    logic [CNT_W-1:0]   r_count;
    logic [LEN_W-1:0]   r_stg_len;
    t_status            r_stg_rej;

    logic [TAG_W-1:0]   r_hdr_client [SLOT_DEPTH];
    logic [TAG_W-1:0]   r_hdr_schema [SLOT_DEPTH];
    logic [LEN_W-1:0]   r_hdr_len    [SLOT_DEPTH];
    logic [BYTE_W-1:0]  r_mem        [SLOT_DEPTH * PAYLOAD_DEPTH];
    logic [BYTE_W-1:0]  r_rd_data;

    logic [SLOT_W-1:0]  r_slot;
    logic [TAG_W-1:0]   r_cli;
    logic [TAG_W-1:0]   r_sch;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_idx;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [TAG_W-1:0]   r_out_client;
    logic [TAG_W-1:0]   r_out_schema;
    logic [BYTE_W-1:0]  r_out_byte;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_last;

    logic [CAP_CMP_W-1:0] eff_cap;
    logic [LEN_W-1:0]     eff_maxb;
    logic [CNT_W-1:0]     tail_inc;
    logic [CNT_W-1:0]     head_inc;
    logic [SLOT_W-1:0]    tail_next;
    logic [SLOT_W-1:0]    head_next;
    t_status              rej_next;
    logic [LEN_W-1:0]     len_inc;
    logic [LEN_W-1:0]     h_len_raw;
    logic [LEN_W-1:0]     h_len;
    logic [LEN_W-1:0]     idx_inc;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;

    // saturate config to its legal range
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CAP_CMP_W'(1);
        end else if (CAP_CMP_W'(r_cap) > CAP_CMP_W'(SLOT_DEPTH)) begin
            eff_cap = CAP_CMP_W'(SLOT_DEPTH);
        end else begin
            eff_cap = CAP_CMP_W'(r_cap);
        end
        if (r_maxb == '0) begin
            eff_maxb = LEN_W'(1);
        end else if (r_maxb > LEN_W'(PAYLOAD_DEPTH)) begin
            eff_maxb = LEN_W'(PAYLOAD_DEPTH);
        end else begin
            eff_maxb = r_maxb;
        end
    end

    // ring index advance with wrap at the current capacity
    always_comb begin
        tail_inc  = CNT_W'(r_tail) + CNT_W'(1);
        head_inc  = CNT_W'(r_head) + CNT_W'(1);
        tail_next = (CAP_CMP_W'(tail_inc) >= eff_cap) ? '0 : tail_inc[SLOT_W-1:0];
        head_next = (CAP_CMP_W'(head_inc) >= eff_cap) ? '0 : head_inc[SLOT_W-1:0];
    end

    // push: too large outranks full, first reject sticks otherwise
    always_comb begin
        if (r_stg_len >= eff_maxb) begin
            rej_next = ST_LARGE;
        end else if (CAP_CMP_W'(r_count) >= eff_cap && r_stg_rej == ST_OK) begin
            rej_next = ST_FULL;
        end else begin
            rej_next = r_stg_rej;
        end
        len_inc = (r_stg_len < LEN_W'(PAYLOAD_DEPTH)) ? r_stg_len + LEN_W'(1) : r_stg_len;
    end

    always_comb begin
        h_len_raw = r_hdr_len[r_head];
        h_len     = (h_len_raw > LEN_W'(PAYLOAD_DEPTH)) ? LEN_W'(PAYLOAD_DEPTH) : h_len_raw;
        idx_inc   = r_idx + LEN_W'(1);

        o_stat.empty       = (r_count == '0);
        o_stat.too_small   = (LIMIT_W'(h_len) > i_pop_limit);
        o_stat.zero_len    = (h_len == '0);
        o_stat.stream_last = (idx_inc == r_len);

        mem_we    = i_cmd.push && (rej_next == ST_OK);
        mem_waddr = pay_addr(r_tail, r_stg_len[PAY_IDX_W-1:0]);
        mem_re    = i_cmd.pop || i_cmd.step;
        mem_raddr = i_cmd.pop ? pay_addr(r_head, '0)
                              : pay_addr(r_slot, idx_inc[PAY_IDX_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_push_byte;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && i_push_last && rej_next == ST_OK) begin
            r_hdr_client[r_tail] <= i_client_in;
            r_hdr_schema[r_tail] <= i_schema_in;
            r_hdr_len[r_tail]    <= len_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_maxb    <= MAXB_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_stg_len <= '0;
            r_stg_rej <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_QUEUE_CAPACITY:    r_cap  <= i_cfg_data[CAP_W-1:0];
                    CFG_MAX_MESSAGE_BYTES: r_maxb <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.push) begin
                if (i_push_last) begin
                    if (rej_next == ST_OK) begin
                        r_tail  <= tail_next;
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_stg_len <= '0;
                    r_stg_rej <= ST_OK;
                end else begin
                    r_stg_len <= len_inc;
                    r_stg_rej <= rej_next;
                end
            end else if (i_cmd.pop) begin
                r_head  <= head_next;
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // message being streamed
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_slot <= r_head;
            r_cli  <= r_hdr_client[r_head];
            r_sch  <= r_hdr_schema[r_head];
            r_len  <= h_len;
            r_idx  <= '0;
        end else if (i_cmd.step) begin
            r_idx <= idx_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.push && i_push_last) || i_cmd.emit || i_cmd.step
                           || (i_cmd.pop && h_len == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= ST_OK;
        r_out_client <= '0;
        r_out_schema <= '0;
        r_out_byte   <= '0;
        r_out_len    <= '0;
        r_out_last   <= 1'b1;
        if (i_cmd.push) begin
            r_out_status <= rej_next;
        end else if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_code;
        end else if (i_cmd.pop) begin
            r_out_client <= r_hdr_client[r_head];
            r_out_schema <= r_hdr_schema[r_head];
        end else if (i_cmd.step) begin
            r_out_client <= r_cli;
            r_out_schema <= r_sch;
            r_out_byte   <= r_rd_data;
            r_out_len    <= r_len;
            r_out_last   <= (idx_inc == r_len);
        end
    end

    assign o_strobe         = r_out_valid;
    assign o_status         = r_out_status;
    assign o_client_out     = r_out_client;
    assign o_schema_out     = r_out_schema;
    assign o_pop_byte       = r_out_byte;
    assign o_message_length = r_out_len;
    assign o_last_result    = r_out_last;

endmodule

@@ hw/rtl/tagged_packet_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// tagged_packet_fifo_unit
// Ring queue of tagged variable-length messages: byte-wise push, pop streams
// the head message one byte per cycle.
// Push: one byte per cycle while no pop stream holds busy, busy stays low; the result
//   of a last byte shows on the cycle after it is taken.
// Pop: status-only answers show on the cycle after the request, busy stays low; a
//   message of N bytes holds busy while it streams, its bytes pass the payload read
//   register and the result register, one per cycle, paced by the payload read port.
// Reset (synchronous, active low) empties the queue and loads capacity 16 and
//   max message 64; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module tagged_packet_fifo_unit import tpf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_opcode,
    input  logic [TAG_W-1:0]      i_client_in,
    input  logic [TAG_W-1:0]      i_schema_in,
    input  logic [BYTE_W-1:0]     i_push_byte,
    input  logic                  i_push_last,
    input  logic [LIMIT_W-1:0]    i_pop_limit,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output logic [2:0]            o_status,
    output logic [TAG_W-1:0]      o_client_out,
    output logic [TAG_W-1:0]      o_schema_out,
    output logic [BYTE_W-1:0]     o_pop_byte,
    output logic [LEN_W-1:0]      o_message_length,
    output logic                  o_last_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tpf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_busy   (o_busy),
        .o_cmd    (cmd)
    );

    tpf_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .i_client_in      (i_client_in),
        .i_schema_in      (i_schema_in),
        .i_push_byte      (i_push_byte),
        .i_push_last      (i_push_last),
        .i_pop_limit      (i_pop_limit),
        .o_stat           (stat),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_client_out     (o_client_out),
        .o_schema_out     (o_schema_out),
        .o_pop_byte       (o_pop_byte),
        .o_message_length (o_message_length),
        .o_last_result    (o_last_result)
    );

endmodule

@@ tb/tb_tagged_packet_fifo_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_packet_fifo_unit
// Self-checking bench for the tagged packet FIFO. A short table of directed
// requests covers empty, too-small, too-large, full and capacity/size limits;
// random phases then stream messages and pops under several register settings
// and sender idle rates. Every response is checked against an in-bench
// prediction of the queue.
// ----------------------------------------------------------------------------
module tb_tagged_packet_fifo_unit;
    import tpf_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 58;

    typedef struct {
        logic             opcode;
        logic [TAG_W-1:0] client;
        logic [TAG_W-1:0] schema;
        logic [BYTE_W-1:0] data;
        logic             last;
        logic [LIMIT_W-1:0] limit;
    } fifo_req_t;

    typedef struct {
        t_status           status;
        logic [TAG_W-1:0]  client;
        logic [TAG_W-1:0]  schema;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  length;
        logic              last;
    } fifo_resp_t;

    typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        fifo_req_t              rq;
        bit                     typed;
        t_status                typed_st;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_val;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  i_opcode = OP_PUSH;
    logic [TAG_W-1:0]      i_client_in = '0;
    logic [TAG_W-1:0]      i_schema_in = '0;
    logic [BYTE_W-1:0]     i_push_byte = '0;
    logic                  i_push_last = 1'b0;
    logic [LIMIT_W-1:0]    i_pop_limit = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_QUEUE_CAPACITY;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_busy;
    logic                  o_strobe;
    logic [2:0]            o_status;
    logic [TAG_W-1:0]      o_client_out;
    logic [TAG_W-1:0]      o_schema_out;
    logic [BYTE_W-1:0]     o_pop_byte;
    logic [LEN_W-1:0]      o_message_length;
    logic                  o_last_result;

    // predicted queue state
    logic [BYTE_W-1:0] pay_mem [SLOT_DEPTH*PAYLOAD_DEPTH];
    logic [TAG_W-1:0]  hdr_client [SLOT_DEPTH];
    logic [TAG_W-1:0]  hdr_schema [SLOT_DEPTH];
    logic [LEN_W-1:0]  hdr_len [SLOT_DEPTH];
    bit                slot_used [SLOT_DEPTH];
    int unsigned       rd_slot, wr_slot, msg_count, stage_len;
    t_status           stage_err;
    logic [CAP_W-1:0]  cap_reg;
    logic [LEN_W-1:0]  maxb_reg;

    fifo_resp_t  awaited[$];
    stim_row_t   opening_rows[$];
    int          errors = 0;
    int          idle_pct = 0;
    int unsigned cycle_count = 0;

    tagged_packet_fifo_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_opcode         (i_opcode),
        .i_client_in      (i_client_in),
        .i_schema_in      (i_schema_in),
        .i_push_byte      (i_push_byte),
        .i_push_last      (i_push_last),
        .i_pop_limit      (i_pop_limit),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_client_out     (o_client_out),
        .o_schema_out     (o_schema_out),
        .o_pop_byte       (o_pop_byte),
        .o_message_length (o_message_length),
        .o_last_result    (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned eff_cap();
        if (cap_reg == 0) return 1;
        if (cap_reg > SLOT_DEPTH) return SLOT_DEPTH;
        return 32'(cap_reg);
    endfunction

    function automatic int unsigned eff_max_len();
        if (maxb_reg == 0) return 1;
        if (maxb_reg > PAYLOAD_DEPTH) return PAYLOAD_DEPTH;
        return 32'(maxb_reg);
    endfunction

    function automatic int unsigned advance_slot(int unsigned s);
        int unsigned n;
        n = s + 1;
        if (n >= eff_cap() || n >= SLOT_DEPTH) n = 0;
        return n;
    endfunction

    function automatic bit all_slots_used();
        for (int k = 0; k < SLOT_DEPTH; k++)
            if (!slot_used[k]) return 0;
        return 1;
    endfunction

    function automatic fifo_resp_t status_only(t_status st);
        fifo_resp_t r;
        r.status = st;
        r.client = '0;
        r.schema = '0;
        r.data   = '0;
        r.length = '0;
        r.last   = 1'b1;
        return r;
    endfunction

    // Applies one accepted request to the predicted queue and queues its responses.
    function automatic int compute_fifo_response(fifo_req_t rq);
        int unsigned slot, len;
        fifo_resp_t  r;
        if (rq.opcode == OP_PUSH) begin
            if (stage_len >= eff_max_len())
                stage_err = ST_LARGE;
            else if (msg_count >= eff_cap() && stage_err == ST_OK)
                stage_err = ST_FULL;
            if (stage_err == ST_OK) pay_mem[wr_slot*PAYLOAD_DEPTH + stage_len] = rq.data;
            if (stage_len < PAYLOAD_DEPTH) stage_len++;
            if (!rq.last) return 0;
            if (stage_err == ST_OK) begin
                hdr_client[wr_slot] = rq.client;
                hdr_schema[wr_slot] = rq.schema;
                hdr_len[wr_slot]    = LEN_W'(stage_len);
                slot_used[wr_slot]  = 1'b1;
                wr_slot = advance_slot(wr_slot);
                msg_count++;
            end
            awaited.push_back(status_only(stage_err));
            stage_len = 0;
            stage_err = ST_OK;
            return 1;
        end
        if (msg_count == 0) begin
            awaited.push_back(status_only(ST_EMPTY));
            return 1;
        end
        slot = rd_slot;
        len  = 32'(hdr_len[slot]);
        if (len > PAYLOAD_DEPTH) len = PAYLOAD_DEPTH;
        if (len > rq.limit) begin
            awaited.push_back(status_only(ST_SMALL));
            return 1;
        end
        rd_slot = advance_slot(rd_slot);
        msg_count--;
        r.status = ST_OK;
        r.client = hdr_client[slot];
        r.schema = hdr_schema[slot];
        r.length = LEN_W'(len);
        if (len == 0) begin
            r.data = '0;
            r.last = 1'b1;
            awaited.push_back(r);
            return 1;
        end
        for (int unsigned k = 0; k < len; k++) begin
            r.data = pay_mem[slot*PAYLOAD_DEPTH + k];
            r.last = (k + 1 == len);
            awaited.push_back(r);
        end
        return len;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge i_clk) begin : response_check
        fifo_resp_t want;
        if (i_rst_n && o_strobe) begin
            if (awaited.size() == 0) begin
                flag_mismatch("response with nothing outstanding", 32'(o_status), 32'd0);
            end else begin
                want = awaited.pop_front();
                if (o_status !== want.status)
                    flag_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_client_out !== want.client)
                    flag_mismatch("client", 32'(o_client_out), 32'(want.client));
                if (o_schema_out !== want.schema)
                    flag_mismatch("schema", 32'(o_schema_out), 32'(want.schema));
                if (o_pop_byte !== want.data)
                    flag_mismatch("pop byte", 32'(o_pop_byte), 32'(want.data));
                if (o_message_length !== want.length)
                    flag_mismatch("length", 32'(o_message_length), 32'(want.length));
                if (o_last_result !== want.last)
                    flag_mismatch("last", 32'(o_last_result), 32'(want.last));
            end
        end
    end

    task automatic issue_request(fifo_req_t rq, bit typed, t_status typed_st);
        int n;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start     = 1'b1;
        i_opcode    = rq.opcode;
        i_client_in = rq.client;
        i_schema_in = rq.schema;
        i_push_byte = rq.data;
        i_push_last = rq.last;
        i_pop_limit = rq.limit;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        n = compute_fifo_response(rq);
        if (typed) begin
            repeat (n) void'(awaited.pop_back());
            awaited.push_back(status_only(typed_st));
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        if (idx == CFG_QUEUE_CAPACITY) cap_reg = val[CAP_W-1:0];
        else maxb_reg = val[LEN_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic add_request(logic op, logic [TAG_W-1:0] c, logic [TAG_W-1:0] s,
                               logic [BYTE_W-1:0] d, logic last, logic [LIMIT_W-1:0] lim,
                               bit typed, t_status st);
        stim_row_t row;
        row.kind      = ROW_REQ;
        row.rq.opcode = op;
        row.rq.client = c;
        row.rq.schema = s;
        row.rq.data   = d;
        row.rq.last   = last;
        row.rq.limit  = lim;
        row.typed     = typed;
        row.typed_st  = st;
        row.cfg_idx   = CFG_QUEUE_CAPACITY;
        row.cfg_val   = '0;
        opening_rows.push_back(row);
    endtask

    task automatic add_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.kind      = ROW_CFG;
        row.rq.opcode = OP_PUSH;
        row.rq.client = '0;
        row.rq.schema = '0;
        row.rq.data   = '0;
        row.rq.last   = 1'b0;
        row.rq.limit  = '0;
        row.typed     = 1'b0;
        row.typed_st  = ST_OK;
        row.cfg_idx   = idx;
        row.cfg_val   = val;
        opening_rows.push_back(row);
    endtask

    function automatic fifo_req_t random_pop();
        fifo_req_t rq;
        int        r;
        rq.opcode = OP_POP;
        rq.client = TAG_W'($urandom_range(0, 65535));
        rq.schema = TAG_W'($urandom_range(0, 65535));
        rq.data   = BYTE_W'($urandom_range(0, 255));
        rq.last   = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 60) rq.limit = LIMIT_W'($urandom_range(0, 70));
        else if (r < 80) rq.limit = 16'hFFFF;
        else if (r < 90) rq.limit = '0;
        else rq.limit = LIMIT_W'($urandom_range(0, 65535));
        return rq;
    endfunction

    function automatic int unsigned pick_length();
        int unsigned em;
        int          r;
        em = eff_max_len();
        r  = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, (em < 8) ? em : 8);
        if (r < 90) return $urandom_range(1, em);
        return em + $urandom_range(1, 3);
    endfunction

    // Well-formed messages with random content, pops mixed in, some inside a message.
    task automatic run_phase(int quota);
        int               sent, pop_pct, msg_left;
        bit               in_msg;
        logic [TAG_W-1:0] c, s;
        fifo_req_t        rq;
        sent = 0;
        in_msg = 0;
        pop_pct = 30;
        msg_left = 0;
        c = '0;
        s = '0;
        while (sent < quota || in_msg) begin
            if (sent % 20 == 0) pop_pct = $urandom_range(10, 65);
            if (!in_msg && $urandom_range(0, 99) < pop_pct) begin
                rq = random_pop();
            end else if (in_msg && sent < quota && $urandom_range(0, 99) < 5) begin
                rq = random_pop();
            end else begin
                if (!in_msg) begin
                    msg_left = pick_length();
                    in_msg = 1;
                    c = TAG_W'($urandom_range(0, 65535));
                    s = TAG_W'($urandom_range(0, 65535));
                end
                if ($urandom_range(0, 4) == 0) begin
                    c = TAG_W'($urandom_range(0, 65535));
                    s = TAG_W'($urandom_range(0, 65535));
                end
                rq.opcode = OP_PUSH;
                rq.client = c;
                rq.schema = s;
                rq.data   = BYTE_W'($urandom_range(0, 255));
                rq.last   = (msg_left == 1);
                rq.limit  = LIMIT_W'($urandom_range(0, 65535));
                msg_left--;
                if (msg_left == 0) in_msg = 0;
            end
            issue_request(rq, 0, ST_OK);
            sent++;
        end
    endtask

    initial begin
        int                    cv, mv;
        stim_row_t             row;

        rd_slot = 0;
        wr_slot = 0;
        msg_count = 0;
        stage_len = 0;
        stage_err = ST_OK;
        cap_reg = CAP_RESET;
        maxb_reg = MAXB_RESET;
        for (int k = 0; k < SLOT_DEPTH; k++) slot_used[k] = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_request(OP_POP,  16'h0, 16'h0, 8'h00, 1'b0, 16'hFFFF, 1, ST_EMPTY);
        add_request(OP_PUSH, 16'h0, 16'h0, 8'h00, 1'b1, 16'h0, 1, ST_OK);
        add_request(OP_POP,  16'h0, 16'h0, 8'h00, 1'b0, 16'h0, 1, ST_SMALL);
        add_request(OP_POP,  16'h0, 16'h0, 8'h00, 1'b0, 16'hFFFF, 0, ST_OK);
        add_request(OP_PUSH, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 16'hFFFF, 0, ST_OK);
        // pop while a push is staged
        add_request(OP_POP,  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 1, ST_EMPTY);
        add_request(OP_PUSH, 16'hFFFF, 16'hFFFF, 8'hA5, 1'b1, 16'h0, 1, ST_OK);
        add_request(OP_POP,  16'h0, 16'h0, 8'h00, 1'b0, 16'd2, 0, ST_OK);
        add_config(CFG_MAX_MESSAGE_BYTES, 7'd2);
        add_request(OP_PUSH, 16'h1234, 16'h5678, 8'h11, 1'b0, 16'h0, 0, ST_OK);
        add_request(OP_PUSH, 16'h1234, 16'h5678, 8'h22, 1'b0, 16'h0, 0, ST_OK);
        add_request(OP_PUSH, 16'h1234, 16'h5678, 8'h33, 1'b1, 16'h0, 1, ST_LARGE);
        add_config(CFG_MAX_MESSAGE_BYTES, 7'd0);
        add_request(OP_PUSH, 16'hAAAA, 16'h5555, 8'h5A, 1'b1, 16'h0, 1, ST_OK);
        add_request(OP_POP,  16'h0, 16'h0, 8'h00, 1'b0, 16'hFFFF, 0, ST_OK);
        add_config(CFG_QUEUE_CAPACITY, 7'd1);
        add_request(OP_PUSH, 16'h0F0F, 16'hF0F0, 8'h3C, 1'b1, 16'h0, 1, ST_OK);
        add_request(OP_PUSH, 16'h0F0F, 16'hF0F0, 8'hC3, 1'b1, 16'h0, 1, ST_FULL);
        // too large outranks full
        add_request(OP_PUSH, 16'h0F0F, 16'hF0F0, 8'h01, 1'b0, 16'h0, 0, ST_OK);
        add_request(OP_PUSH, 16'h0F0F, 16'hF0F0, 8'h02, 1'b1, 16'h0, 1, ST_LARGE);
        add_request(OP_POP,  16'h0, 16'h0, 8'h00, 1'b0, 16'hFFFF, 0, ST_OK);
        add_request(OP_POP,  16'h0, 16'h0, 8'h00, 1'b0, 16'hFFFF, 1, ST_EMPTY);
        add_config(CFG_QUEUE_CAPACITY, 7'd31);
        add_config(CFG_MAX_MESSAGE_BYTES, 7'd127);

        foreach (opening_rows[i]) begin
            row = opening_rows[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_register(row.cfg_idx, row.cfg_val);
            end else begin
                issue_request(row.rq, row.typed, row.typed_st);
            end
        end
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin cv = 16; mv = 64;  idle_pct = 0;  end
                1: begin cv = 4;  mv = 8;   idle_pct = 83; end
                2: begin cv = 31; mv = 127; idle_pct = 16; end
                3: begin cv = 0;  mv = 1;   idle_pct = 0;  end
                4: begin
                    cv = $urandom_range(0, 31);
                    mv = $urandom_range(0, 127);
                    idle_pct = 83;
                end
                default: begin cv = 2; mv = 16; idle_pct = 16; end
            endcase
            // never let a pop reach a slot that was not written yet
            if (msg_count != 0 && !all_slots_used()) cv = int'(cap_reg);
            write_register(CFG_QUEUE_CAPACITY, CFG_DATA_W'(cv));
            write_register(CFG_MAX_MESSAGE_BYTES, CFG_DATA_W'(mv));
            run_phase(PHASE_ITEMS);
            settle();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ tagged_packet_fifo_unit.f @@
hw/rtl/tpf_pkg.sv
hw/rtl/tpf_ctrl.sv
hw/rtl/tpf_datapath.sv
hw/rtl/tagged_packet_fifo_unit.sv
tb/tb_tagged_packet_fifo_unit.sv
